/* hw/rtl/cfe_pkg.sv */
// Shared types and constants for the CSV field extractor.
// Used by cfe_parser, cfe_out_buf and csv_field_extractor; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfe_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FETCH_FIELD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 2'd2;

    // Register reset values.
    localparam logic [7:0]         SEPARATOR_RST   = 8'd44;
    localparam logic signed [16:0] FETCH_FIELD_RST = 17'sd0;
    localparam logic [8:0]         CAPACITY_RST    = 9'd256;

    // Field buffer capacity limit and counter saturation points.
    localparam logic [8:0]  MAX_FIELD_LEN = 9'd256;
    localparam logic [15:0] CNT_MAX       = 16'hFFFF;
    localparam logic [15:0] OFFSET_CAP    = 16'hFFFF;

    // One result transaction.
    typedef struct packed {
        logic        char_valid;
        logic [7:0]  char_out;
        logic [7:0]  char_pos;
        logic        record_done;
        logic [15:0] field_count;
        logic        fetch_ok;
        logic        start_found;
        logic [15:0] start_offset;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/cfe_parser.sv */
// Record parser: configuration registers, field tracking state and the
// per-byte result logic. Depends on cfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfe_parser (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [cfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cfe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          accept,
    input  wire logic [7:0]                    char_byte,
    input  wire logic                          end_of_text,
    output cfe_pkg::result_t                   result
);

    typedef enum logic [1:0] {
        PH_INIT = 2'd0,
        PH_ACC  = 2'd1,
        PH_SEP  = 2'd2
    } phase_t;

    // Configuration registers.
    logic [7:0]         separator_reg;
    logic signed [16:0] fetch_field_reg;
    logic [8:0]         capacity_reg;

    // Record state.
    phase_t      phase_reg, phase_next;
    logic [15:0] field_number_reg, field_number_next;
    logic [8:0]  char_index_reg, char_index_next;
    logic [15:0] fields_seen_reg, fields_seen_next;
    logic [15:0] byte_offset_reg, byte_offset_next;
    logic [15:0] start_pos_reg, start_pos_next;
    logic        start_seen_reg, start_seen_next;
    logic        field_complete_reg, field_complete_next;
    logic        overflow_err_reg, overflow_err_next;

    // Helper terms for the current byte.
    logic        in_field;
    logic        is_sep;
    logic        is_term;
    logic        fetch_match;
    logic [8:0]  cap;
    logic [8:0]  idx_inc;
    logic [8:0]  pos;
    logic [15:0] fields_inc;
    logic [15:0] number_inc;
    logic [15:0] offset_inc;

    assign in_field    = (phase_reg == PH_ACC);
    assign is_sep      = (char_byte == separator_reg);
    assign is_term     = end_of_text || is_sep;
    assign fetch_match = !fetch_field_reg[16] && (fetch_field_reg[15:0] == field_number_reg);
    assign cap         = (capacity_reg > cfe_pkg::MAX_FIELD_LEN) ? cfe_pkg::MAX_FIELD_LEN
                                                                 : capacity_reg;
    assign idx_inc     = (char_index_reg < cfe_pkg::MAX_FIELD_LEN) ? char_index_reg + 9'd1
                                                                   : char_index_reg;
    assign pos         = in_field ? idx_inc : 9'd0;
    assign fields_inc  = (fields_seen_reg < cfe_pkg::CNT_MAX) ? fields_seen_reg + 16'd1
                                                              : fields_seen_reg;
    assign number_inc  = (field_number_reg < cfe_pkg::CNT_MAX) ? field_number_reg + 16'd1
                                                               : field_number_reg;
    assign offset_inc  = (byte_offset_reg < cfe_pkg::OFFSET_CAP) ? byte_offset_reg + 16'd1
                                                                 : byte_offset_reg;

    // Next state and result for one accepted byte or end marker.
    always_comb
    begin
        phase_next          = phase_reg;
        field_number_next   = field_number_reg;
        char_index_next     = char_index_reg;
        fields_seen_next    = fields_seen_reg;
        byte_offset_next    = byte_offset_reg;
        start_pos_next      = start_pos_reg;
        start_seen_next     = start_seen_reg;
        field_complete_next = field_complete_reg;
        overflow_err_next   = overflow_err_reg;
        result              = '0;

        if (accept)
        begin
            // A new field starts whenever we are not inside one.
            if (!in_field)
            begin
                fields_seen_next = fields_inc;
            end

            // Place a character or the terminator of the fetched field.
            if (fetch_match)
            begin
                if (pos == 9'd0)
                begin
                    start_pos_next  = byte_offset_reg;
                    start_seen_next = 1'b1;
                end
                if (pos < cap)
                begin
                    if (is_term)
                    begin
                        field_complete_next = 1'b1;
                    end
                    else
                    begin
                        result.char_valid = 1'b1;
                        result.char_out   = char_byte;
                        result.char_pos   = pos[7:0];
                    end
                end
                else
                begin
                    overflow_err_next = 1'b1;
                end
            end

            if (end_of_text)
            begin
                // Report the record, then clear for the next one.
                result.record_done  = 1'b1;
                result.field_count  = fields_seen_next;
                result.fetch_ok     = field_complete_next && !overflow_err_next;
                result.start_found  = start_seen_next;
                result.start_offset = start_seen_next ? start_pos_next : 16'd0;

                phase_next          = PH_INIT;
                field_number_next   = '0;
                char_index_next     = '0;
                fields_seen_next    = '0;
                byte_offset_next    = '0;
                start_pos_next      = '0;
                start_seen_next     = 1'b0;
                field_complete_next = 1'b0;
                overflow_err_next   = 1'b0;
            end
            else
            begin
                if (is_sep)
                begin
                    char_index_next   = '0;
                    field_number_next = number_inc;
                    phase_next        = PH_SEP;
                end
                else
                begin
                    char_index_next = pos;
                    phase_next      = PH_ACC;
                end
                byte_offset_next = offset_inc;
            end
        end
    end

    // State and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg      <= cfe_pkg::SEPARATOR_RST;
            fetch_field_reg    <= cfe_pkg::FETCH_FIELD_RST;
            capacity_reg       <= cfe_pkg::CAPACITY_RST;
            phase_reg          <= PH_INIT;
            field_number_reg   <= '0;
            char_index_reg     <= '0;
            fields_seen_reg    <= '0;
            byte_offset_reg    <= '0;
            start_pos_reg      <= '0;
            start_seen_reg     <= 1'b0;
            field_complete_reg <= 1'b0;
            overflow_err_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    cfe_pkg::REG_SEPARATOR:   separator_reg   <= cfg_data[7:0];
                    cfe_pkg::REG_FETCH_FIELD: fetch_field_reg <= cfg_data;
                    cfe_pkg::REG_CAPACITY:    capacity_reg    <= cfg_data[8:0];
                    default:                  ;
                endcase
            end
            phase_reg          <= phase_next;
            field_number_reg   <= field_number_next;
            char_index_reg     <= char_index_next;
            fields_seen_reg    <= fields_seen_next;
            byte_offset_reg    <= byte_offset_next;
            start_pos_reg      <= start_pos_next;
            start_seen_reg     <= start_seen_next;
            field_complete_reg <= field_complete_next;
            overflow_err_reg   <= overflow_err_next;
        end
    end

    // An end marker always leaves the parser cleared.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_text |=> phase_reg == PH_INIT && fields_seen_reg == 16'd0)
        else $error("record state not cleared after end marker");

    // Leaving the initial phase always counts a field.
    a_phase_counts: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_INIT |-> fields_seen_reg != 16'd0)
        else $error("field count zero outside initial phase");

    // Character index is only nonzero inside a field.
    a_index_idle: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_ACC |-> char_index_reg == 9'd0)
        else $error("character index nonzero outside a field");

    // A recorded start implies the record is in progress.
    a_start_in_record: assert property (@(posedge clk) disable iff (!rst_n)
        start_seen_reg |-> phase_reg != PH_INIT)
        else $error("field start recorded with no record in progress");

endmodule

`default_nettype wire

/* hw/rtl/cfe_out_buf.sv */
// Two-entry result buffer between the parser and the output channel.
// Depends on cfe_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module cfe_out_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire cfe_pkg::result_t push_data,
    output logic                  full,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output cfe_pkg::result_t      out_data
);

    cfe_pkg::result_t mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // A pushed result is visible in the next cycle.
    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> count_reg != 2'd0)
        else $error("pushed result lost");

    // No push into a full buffer.
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full result buffer");

    // Pointers differ exactly when the buffer holds one entry.
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg != rd_ptr_reg) == (count_reg == 2'd1))
        else $error("buffer pointers disagree with count");

endmodule

`default_nettype wire

/* hw/rtl/csv_field_extractor.sv */
// Top level of the CSV field extractor: parser plus output result buffer.
// Depends on cfe_pkg, cfe_parser and cfe_out_buf.
//
//   Channel   Direction  Handshake              Payload
//   input     in         in_valid / in_stall    char_byte, end_of_text
//   output    out        out_valid / out_stall  char_valid .. start_offset
//   config    in         cfg_write_en           cfg_index, cfg_data
//
// One input transaction is accepted per clock while in_stall is low; its result is
// registered in the result buffer before it appears on the output.
// The two-entry result buffer keeps input flowing while one result waits;
// in_stall rises only when both entries are occupied.
// Reset clears the record state and loads separator 44, fetched field
// number 0 and field capacity 256.
`timescale 1ns / 1ps
`default_nettype none

module csv_field_extractor (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_en,
    input  wire logic [cfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cfe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [7:0]                     char_byte,
    input  wire logic                           end_of_text,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                char_valid,
    output logic [7:0]                          char_out,
    output logic [7:0]                          char_pos,
    output logic                                record_done,
    output logic [15:0]                         field_count,
    output logic                                fetch_ok,
    output logic                                start_found,
    output logic [15:0]                         start_offset
);

    logic             accept;
    logic             buf_full;
    cfe_pkg::result_t parse_result;
    cfe_pkg::result_t out_result;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    // Per-transaction parsing.
    cfe_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .char_byte    (char_byte),
        .end_of_text  (end_of_text),
        .result       (parse_result)
    );

    // Result register and skid storage.
    cfe_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (parse_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_result)
    );

    assign char_valid   = out_result.char_valid;
    assign char_out     = out_result.char_out;
    assign char_pos     = out_result.char_pos;
    assign record_done  = out_result.record_done;
    assign field_count  = out_result.field_count;
    assign fetch_ok     = out_result.fetch_ok;
    assign start_found  = out_result.start_found;
    assign start_offset = out_result.start_offset;

endmodule

`default_nettype wire
